### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("property violated");
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### sv/ttok_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text tokenizer package
// Payload, configuration and bundle types, codes and defaults.
// ---------------------------------------------------------------------------
package ttok_pkg;

  localparam int OFFSET_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int MARKER_BYTES        = 4;
  localparam int MAX_RESULTS         = 3;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NL_DROP        = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [2:0] {
    KIND_WORD     = 3'd0,
    KIND_QUOTED   = 3'd1,
    KIND_NEWLINE  = 3'd2,
    KIND_END      = 3'd3,
    KIND_UNCLOSED = 3'd4
  } tt_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_MATCH   = 3'd1,
    PH_WORD    = 3'd2,
    PH_QUOTE   = 3'd3,
    PH_COMMENT = 3'd4
  } tt_phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } tt_in_t;

  typedef struct packed {
    tt_kind_t    token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        end_of_run;
    logic        range_overflow;
  } tt_out_t;

  typedef struct packed {
    logic [2:0]  comment_length;
    logic [31:0] comment_bytes;
    logic        nl_drop;
  } tt_cfg_t;

  // All results caused by one byte, in order; cnt is 1..MAX_RESULTS when queued.
  typedef struct packed {
    logic [1:0]                 cnt;
    tt_out_t [MAX_RESULTS-1:0]  res;
  } tt_bundle_t;

endpackage

### sv/ttok_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tokenizer bundle queue
// Small FIFO of per-byte result bundles between the scanner and the output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttok_queue #(
  parameter int QUEUE_DEPTH = ttok_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ttok_pkg::tt_bundle_t push_data,
  output logic                 full,
  input  logic                 pop,
  output ttok_pkg::tt_bundle_t head,
  output logic                 not_empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ttok_pkg::tt_bundle_t entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full)
  `ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && !not_empty)

endmodule

### sv/ttok_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tokenizer scanner
// Accepts one byte a cycle while the queue has room, tracks token state and builds the result bundle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttok_front #(
  parameter int OFFSET_BITS = ttok_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ttok_pkg::tt_cfg_t    cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ttok_pkg::tt_in_t     in_data,
  input  logic                 q_full,
  output logic                 push,
  output ttok_pkg::tt_bundle_t push_data
);

  localparam int          OW    = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
  localparam logic [OW-1:0] LIMIT = {OW{1'b1}};

  function automatic ttok_pkg::tt_bundle_t put_result(
    input ttok_pkg::tt_bundle_t bd,
    input ttok_pkg::tt_kind_t   kind,
    input logic [15:0]          start,
    input logic [15:0]          len,
    input logic [15:0]          line_no,
    input logic                 ovf
  );
    ttok_pkg::tt_out_t r;
    r.token_kind     = kind;
    r.token_start    = start;
    r.token_length   = len;
    r.line_number    = line_no;
    r.end_of_run     = 1'b0;
    r.range_overflow = ovf;
    if (bd.cnt < 2'(ttok_pkg::MAX_RESULTS)) begin
      bd.res[bd.cnt] = r;
      bd.cnt         = bd.cnt + 2'd1;
    end
    return bd;
  endfunction

  function automatic logic [7:0] marker_byte(input logic [31:0] bytes, input logic [2:0] idx);
    logic [63:0] ext;
    ext = {32'b0, bytes};
    return ext[8*idx +: 8];
  endfunction

  ttok_pkg::tt_phase_t phase_r, phase_nxt;
  logic [OW-1:0] offset_r, offset_nxt;
  logic [OW-1:0] begin_r, begin_nxt;
  logic [15:0]   line_r, line_nxt;
  logic [2:0]    matched_r, matched_nxt;
  logic          bslash_r, bslash_nxt;
  logic          cr_r, cr_nxt;
  logic          ovf_r, ovf_nxt;

  logic          accept;
  logic [7:0]    cur_byte;
  logic [OW-1:0] cur_off;
  logic [OW-1:0] next_off;
  logic [3:0]    mlen;
  logic          is_ws;
  logic          do_idle;
  logic          unclosed;
  ttok_pkg::tt_bundle_t bd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push      = accept && (bd.cnt != 2'd0);
  assign push_data = bd;

  always_comb begin
    phase_nxt   = phase_r;
    offset_nxt  = offset_r;
    begin_nxt   = begin_r;
    line_nxt    = line_r;
    matched_nxt = matched_r;
    bslash_nxt  = bslash_r;
    cr_nxt      = cr_r;
    ovf_nxt     = ovf_r;
    bd          = '0;
    do_idle     = 1'b0;
    unclosed    = 1'b0;
    cur_byte    = in_data.in_byte;
    cur_off     = offset_r;
    next_off    = (offset_r < LIMIT) ? offset_r + OW'(1) : LIMIT;
    mlen        = ({1'b0, cfg.comment_length} > 4'(ttok_pkg::MARKER_BYTES))
                  ? 4'(ttok_pkg::MARKER_BYTES) : {1'b0, cfg.comment_length};
    is_ws       = (cur_byte == ttok_pkg::CH_SPACE) || (cur_byte == ttok_pkg::CH_TAB) ||
                  (cur_byte == ttok_pkg::CH_CR) || (cur_byte == ttok_pkg::CH_LF);

    // Resolve a held CR first: CRLF folds into one two-byte line break.
    if (cr_r) begin
      cr_nxt = 1'b0;
      if (line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
      else                      ovf_nxt  = 1'b1;
      if (!cfg.nl_drop) begin
        bd = put_result(bd, ttok_pkg::KIND_NEWLINE, 16'(begin_nxt),
                        (cur_byte == ttok_pkg::CH_LF) ? 16'd2 : 16'd1, line_nxt, ovf_nxt);
      end
    end

    if (!(cr_r && cur_byte == ttok_pkg::CH_LF)) begin
      case (phase_r)
        ttok_pkg::PH_MATCH: begin
          if (is_ws) begin
            bd = put_result(bd, ttok_pkg::KIND_WORD, 16'(begin_nxt),
                            16'(cur_off - begin_nxt), line_nxt, ovf_nxt);
            do_idle = 1'b1;
          end else if (cur_byte == marker_byte(cfg.comment_bytes, matched_r)) begin
            matched_nxt = matched_r + 3'd1;
            if (({1'b0, matched_nxt} >= mlen) || (matched_nxt == 3'd0)) begin
              phase_nxt   = ttok_pkg::PH_COMMENT;
              matched_nxt = 3'd0;
            end
          end else begin
            phase_nxt   = ttok_pkg::PH_WORD;
            matched_nxt = 3'd0;
          end
        end
        ttok_pkg::PH_WORD: begin
          if (is_ws) begin
            bd = put_result(bd, ttok_pkg::KIND_WORD, 16'(begin_nxt),
                            16'(cur_off - begin_nxt), line_nxt, ovf_nxt);
            do_idle = 1'b1;
          end
        end
        ttok_pkg::PH_COMMENT: begin
          if (cur_byte == ttok_pkg::CH_CR || cur_byte == ttok_pkg::CH_LF) do_idle = 1'b1;
        end
        ttok_pkg::PH_QUOTE: begin
          if (cur_byte == ttok_pkg::CH_QUOTE && !bslash_r) begin
            if (cur_off != begin_nxt) begin
              bd = put_result(bd, ttok_pkg::KIND_QUOTED, 16'(begin_nxt),
                              16'(cur_off - begin_nxt), line_nxt, ovf_nxt);
            end
            phase_nxt  = ttok_pkg::PH_IDLE;
            bslash_nxt = 1'b0;
          end else begin
            bslash_nxt = (cur_byte == ttok_pkg::CH_BSLASH);
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    // Between tokens: classify the byte that may open the next token.
    if (do_idle) begin
      phase_nxt   = ttok_pkg::PH_IDLE;
      matched_nxt = 3'd0;
      if (cur_byte == ttok_pkg::CH_SPACE || cur_byte == ttok_pkg::CH_TAB) begin
        phase_nxt = ttok_pkg::PH_IDLE;
      end else if (cur_byte == ttok_pkg::CH_CR) begin
        begin_nxt = cur_off;
        cr_nxt    = 1'b1;
      end else if (cur_byte == ttok_pkg::CH_LF) begin
        if (line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
        else                      ovf_nxt  = 1'b1;
        if (!cfg.nl_drop) begin
          bd = put_result(bd, ttok_pkg::KIND_NEWLINE, 16'(cur_off), 16'd1, line_nxt, ovf_nxt);
        end
      end else if (cur_byte == ttok_pkg::CH_QUOTE) begin
        phase_nxt  = ttok_pkg::PH_QUOTE;
        begin_nxt  = next_off;
        bslash_nxt = 1'b0;
      end else if (mlen != 4'd0 && cur_byte == marker_byte(cfg.comment_bytes, 3'd0)) begin
        begin_nxt = cur_off;
        if (mlen == 4'd1) begin
          phase_nxt = ttok_pkg::PH_COMMENT;
        end else begin
          phase_nxt   = ttok_pkg::PH_MATCH;
          matched_nxt = 3'd1;
        end
      end else begin
        begin_nxt = cur_off;
        phase_nxt = ttok_pkg::PH_WORD;
      end
    end

    if (cur_off == LIMIT) ovf_nxt = 1'b1;
    offset_nxt = next_off;

    // Close out the buffer and return to the reset state.
    if (in_data.in_last) begin
      if (cr_nxt) begin
        if (line_nxt != 16'hFFFF) line_nxt = line_nxt + 16'd1;
        else                      ovf_nxt  = 1'b1;
        if (!cfg.nl_drop) begin
          bd = put_result(bd, ttok_pkg::KIND_NEWLINE, 16'(begin_nxt), 16'd1, line_nxt, ovf_nxt);
        end
      end
      if (phase_nxt == ttok_pkg::PH_MATCH || phase_nxt == ttok_pkg::PH_WORD) begin
        bd = put_result(bd, ttok_pkg::KIND_WORD, 16'(begin_nxt),
                        16'(next_off - begin_nxt), line_nxt, ovf_nxt);
      end else if (phase_nxt == ttok_pkg::PH_QUOTE) begin
        bd = put_result(bd, ttok_pkg::KIND_UNCLOSED, 16'(begin_nxt),
                        16'(next_off - begin_nxt), line_nxt, ovf_nxt);
        unclosed = 1'b1;
      end
      if (!unclosed) begin
        bd = put_result(bd, ttok_pkg::KIND_END, 16'(next_off), 16'd0, line_nxt, ovf_nxt);
      end
      phase_nxt   = ttok_pkg::PH_IDLE;
      offset_nxt  = '0;
      begin_nxt   = '0;
      line_nxt    = '0;
      matched_nxt = 3'd0;
      bslash_nxt  = 1'b0;
      cr_nxt      = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ttok_pkg::PH_IDLE;
      offset_r  <= '0;
      begin_r   <= '0;
      line_r    <= '0;
      matched_r <= '0;
      bslash_r  <= 1'b0;
      cr_r      <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      offset_r  <= offset_nxt;
      begin_r   <= begin_nxt;
      line_r    <= line_nxt;
      matched_r <= matched_nxt;
      bslash_r  <= bslash_nxt;
      cr_r      <= cr_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  `ASSERT_PROP(a_cr_only_idle, clk, rst_n, cr_r |-> phase_r == ttok_pkg::PH_IDLE)
  `ASSERT_PROP(a_last_clears, clk, rst_n,
    accept && in_data.in_last |=> phase_r == ttok_pkg::PH_IDLE && offset_r == '0 && line_r == '0)

endmodule

### sv/ttok_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tokenizer result serializer
// Unpacks queued bundles into single results through an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttok_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ttok_pkg::tt_bundle_t head,
  input  logic                 q_not_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ttok_pkg::tt_out_t    out_data
);

  logic                out_valid_r, out_valid_nxt;
  ttok_pkg::tt_out_t   out_data_r, out_data_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                load;
  logic                is_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;
  assign is_last   = (idx_r == head.cnt - 2'd1);
  assign pop       = load && q_not_empty && is_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = q_not_empty;
      if (q_not_empty) begin
        out_data_nxt            = head.res[idx_r];
        out_data_nxt.end_of_run = is_last;
        idx_nxt                 = is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `ASSERT_PROP(a_pop_marks_end, clk, rst_n, pop |=> out_valid_r && out_data_r.end_of_run)

endmodule

### sv/text_tokenizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text tokenizer
// Splits a byte stream into word, quoted, newline, unclosed-quote and end-of-buffer tokens.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) moves one text byte per
//   beat, with in_last on the final byte of a buffer. Output channel
//   (out_valid / out_stall / out_data) moves one token descriptor per beat;
//   end_of_run marks the last descriptor caused by a given byte.
//   Write cfg_comment registers through cfg_we / cfg_index / cfg_wdata only
//   while no buffer is in flight.
// Timing:
//   One byte is taken every cycle while the bundle queue has room. A byte's
//   results enter the queue as it is taken and leave via the output register.
//   Each result needs its own output beat, so a byte that yields k results
//   (up to three, e.g. a word closed by a line break on the last byte) uses k
//   output beats; the queue absorbs those bursts and the output beat rate sets the pace.
// Reset: rst_n low clears scan state, queue and output register; config
//   registers return to zero (comments off, newline tokens on).
// Stall: out_stall holds the output register; the queue fills and then
//   in_stall rises until the receiver takes beats again.
// ---------------------------------------------------------------------------
module text_tokenizer #(
  parameter int OFFSET_BITS = ttok_pkg::OFFSET_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = ttok_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ttok_pkg::tt_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ttok_pkg::tt_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [ttok_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttok_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Configuration registers; writes to unknown indexes drop silently.
  ttok_pkg::tt_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ttok_pkg::CFG_COMMENT_LENGTH: cfg_nxt.comment_length = cfg_wdata[2:0];
        ttok_pkg::CFG_COMMENT_BYTES:  cfg_nxt.comment_bytes  = cfg_wdata[31:0];
        ttok_pkg::CFG_NL_DROP:        cfg_nxt.nl_drop        = cfg_wdata[0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: scanner producing one bundle per byte that has results.
  logic                 q_full;
  logic                 q_push;
  ttok_pkg::tt_bundle_t q_push_data;
  logic                 q_pop;
  ttok_pkg::tt_bundle_t q_head;
  logic                 q_not_empty;

  ttok_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // Queue: decouples scanner stalls from output stalls.
  ttok_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  // Back: drain each bundle one result per output beat.
  ttok_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_not_empty (q_not_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### tb/tt_token_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Token checker
// Watches the byte, token and register ports of the text tokenizer, keeps
// its own scan state, predicts the token descriptors of every accepted byte
// and compares each output beat, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module tt_token_checker #(
  parameter int OFFSET_BITS = ttok_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  ttok_pkg::tt_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  ttok_pkg::tt_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [ttok_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttok_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              tokens_due
);

  localparam int          POS_MAX_I = (OFFSET_BITS >= 16) ? 65535 : (1 << OFFSET_BITS) - 1;
  localparam logic [15:0] POS_MAX   = 16'(POS_MAX_I);

  // Register copies.
  logic [2:0]  mark_len_r;
  logic [31:0] mark_bytes_r;
  logic        skip_nl_r;

  // Scan state.
  ttok_pkg::tt_phase_t phase;
  logic [15:0] pos;
  logic [15:0] tok_start;
  logic [15:0] lines;
  logic [2:0]  matched;
  logic        escaped;
  logic        cr_held;
  logic        saturated;

  ttok_pkg::tt_out_t step_res [ttok_pkg::MAX_RESULTS];
  int                step_cnt;
  ttok_pkg::tt_out_t pending_tokens [$];
  int                errs = 0;

  function automatic logic [2:0] active_len();
    return (mark_len_r > ttok_pkg::MARKER_BYTES) ? 3'(ttok_pkg::MARKER_BYTES) : mark_len_r;
  endfunction

  // Marker bytes past the fourth read as zero.
  function automatic logic [7:0] marker_at(logic [2:0] idx);
    return (idx < 3'd4) ? mark_bytes_r[idx*8 +: 8] : 8'h00;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == ttok_pkg::CH_SPACE || b == ttok_pkg::CH_TAB ||
           b == ttok_pkg::CH_CR || b == ttok_pkg::CH_LF;
  endfunction

  function automatic void clear_scan();
    phase     = ttok_pkg::PH_IDLE;
    pos       = '0;
    tok_start = '0;
    lines     = '0;
    matched   = '0;
    escaped   = 1'b0;
    cr_held   = 1'b0;
    saturated = 1'b0;
  endfunction

  function automatic void emit(ttok_pkg::tt_kind_t kind, logic [15:0] start, logic [15:0] len);
    ttok_pkg::tt_out_t r;
    if (step_cnt >= ttok_pkg::MAX_RESULTS) return;
    r.token_kind     = kind;
    r.token_start    = start;
    r.token_length   = len;
    r.line_number    = lines;
    r.end_of_run     = 1'b0;
    r.range_overflow = saturated;
    step_res[step_cnt] = r;
    step_cnt++;
  endfunction

  function automatic void count_line(logic [15:0] start, logic [15:0] len);
    if (lines != 16'hFFFF) lines++;
    else saturated = 1'b1;
    if (!skip_nl_r) emit(ttok_pkg::KIND_NEWLINE, start, len);
  endfunction

  // Byte seen between tokens: open a word, quote, marker match or line break.
  function automatic void start_token(logic [7:0] b, logic [15:0] p, logic [15:0] nxt);
    phase   = ttok_pkg::PH_IDLE;
    matched = '0;
    if (b == ttok_pkg::CH_CR) begin
      tok_start = p;
      cr_held   = 1'b1;
    end else if (b == ttok_pkg::CH_LF) begin
      count_line(p, 16'd1);
    end else if (b == ttok_pkg::CH_QUOTE) begin
      phase     = ttok_pkg::PH_QUOTE;
      tok_start = nxt;
      escaped   = 1'b0;
    end else if (b != ttok_pkg::CH_SPACE && b != ttok_pkg::CH_TAB) begin
      tok_start = p;
      if (active_len() != 3'd0 && b == marker_at(3'd0)) begin
        if (active_len() == 3'd1) begin
          phase = ttok_pkg::PH_COMMENT;
        end else begin
          phase   = ttok_pkg::PH_MATCH;
          matched = 3'd1;
        end
      end else begin
        phase = ttok_pkg::PH_WORD;
      end
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic last);
    logic [15:0] p;
    logic [15:0] nxt;
    logic        crlf;
    logic        unclosed;
    p        = pos;
    nxt      = (p < POS_MAX) ? p + 16'd1 : POS_MAX;
    crlf     = 1'b0;
    unclosed = 1'b0;
    step_cnt = 0;
    if (cr_held) begin
      cr_held = 1'b0;
      crlf    = (b == ttok_pkg::CH_LF);
      count_line(tok_start, crlf ? 16'd2 : 16'd1);
    end
    if (!crlf) begin
      case (phase)
        ttok_pkg::PH_MATCH: begin
          if (is_blank(b)) begin
            emit(ttok_pkg::KIND_WORD, tok_start, p - tok_start);
            start_token(b, p, nxt);
          end else if (b == marker_at(matched)) begin
            matched = matched + 3'd1;
            if (matched >= active_len() || matched == 3'd0) begin
              phase   = ttok_pkg::PH_COMMENT;
              matched = '0;
            end
          end else begin
            phase   = ttok_pkg::PH_WORD;
            matched = '0;
          end
        end
        ttok_pkg::PH_WORD: begin
          if (is_blank(b)) begin
            emit(ttok_pkg::KIND_WORD, tok_start, p - tok_start);
            start_token(b, p, nxt);
          end
        end
        ttok_pkg::PH_COMMENT: begin
          if (b == ttok_pkg::CH_CR || b == ttok_pkg::CH_LF) start_token(b, p, nxt);
        end
        ttok_pkg::PH_QUOTE: begin
          if (b == ttok_pkg::CH_QUOTE && !escaped) begin
            if (p != tok_start) emit(ttok_pkg::KIND_QUOTED, tok_start, p - tok_start);
            phase   = ttok_pkg::PH_IDLE;
            escaped = 1'b0;
          end else begin
            escaped = (b == ttok_pkg::CH_BSLASH);
          end
        end
        default: start_token(b, p, nxt);
      endcase
    end
    if (p >= POS_MAX) saturated = 1'b1;
    pos = nxt;
    if (last) begin
      if (cr_held) begin
        cr_held = 1'b0;
        count_line(tok_start, 16'd1);
      end
      if (phase == ttok_pkg::PH_MATCH || phase == ttok_pkg::PH_WORD) begin
        emit(ttok_pkg::KIND_WORD, tok_start, nxt - tok_start);
      end else if (phase == ttok_pkg::PH_QUOTE) begin
        emit(ttok_pkg::KIND_UNCLOSED, tok_start, nxt - tok_start);
        unclosed = 1'b1;
      end
      if (!unclosed) emit(ttok_pkg::KIND_END, nxt, 16'd0);
      clear_scan();
    end
    for (int i = 0; i < step_cnt; i++) begin
      if (i == step_cnt - 1) step_res[i].end_of_run = 1'b1;
      pending_tokens.push_back(step_res[i]);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: token %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    ttok_pkg::tt_out_t want;
    if (!rst_n) begin
      mark_len_r   = '0;
      mark_bytes_r = '0;
      skip_nl_r    = 1'b0;
      clear_scan();
      pending_tokens.delete();
    end else begin
      // Compare before predicting: a beat leaving now belongs to an older byte.
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected token beat: kind %0d start %0d length %0d line %0d",
                   $time, out_data.token_kind, out_data.token_start,
                   out_data.token_length, out_data.line_number);
          errs++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("kind", want.token_kind, out_data.token_kind);
          check_field("start", want.token_start, out_data.token_start);
          check_field("length", want.token_length, out_data.token_length);
          check_field("line", want.line_number, out_data.line_number);
          check_field("end_of_run", want.end_of_run, out_data.end_of_run);
          check_field("overflow", want.range_overflow, out_data.range_overflow);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ttok_pkg::CFG_COMMENT_LENGTH: mark_len_r   = cfg_wdata[2:0];
          ttok_pkg::CFG_COMMENT_BYTES:  mark_bytes_r = cfg_wdata[31:0];
          ttok_pkg::CFG_NL_DROP:        skip_nl_r    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) tokenize_byte(in_data.in_byte, in_data.in_last);
    end
    tokens_due <= pending_tokens.size();
    fail_count <= errs;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text tokenizer testbench
// Feeds directed and random text buffers through the tokenizer under
// several comment and newline settings and idling patterns. A checker
// beside the block predicts and compares every token beat.
// ---------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 8;      // covers the queue and the output register
  localparam int PHASE_BYTES  = 48;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  ttok_pkg::tt_in_t                in_data;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  ttok_pkg::tt_out_t               out_data;
  logic                            cfg_we;
  logic [ttok_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ttok_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int tokens_due;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  // Marker currently programmed; the random text uses it to build comments.
  logic [2:0]  cur_len    = '0;
  logic [31:0] cur_marker = '0;

  logic [7:0]  text_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tt_token_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .tokens_due (tokens_due)
  );

  // Receiver: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Move one byte. Drop valid for a random gap first, then hold the beat
  // until the block takes it. Valid stays high between back-to-back beats.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send a string; flag its final byte as the end of the buffer if asked.
  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // Pause the sender until every predicted token has left, then let the
  // pipeline empty of bytes that made no token.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Program all three registers on consecutive edges, with the block idle.
  task automatic set_config(input logic [2:0] len, input logic [31:0] marker,
                            input logic skip);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= ttok_pkg::CFG_COMMENT_LENGTH;
    cfg_wdata <= {29'd0, len};
    @(posedge clk);
    cfg_index <= ttok_pkg::CFG_COMMENT_BYTES;
    cfg_wdata <= marker;
    @(posedge clk);
    cfg_index <= ttok_pkg::CFG_NL_DROP;
    cfg_wdata <= {31'd0, skip};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_len    = len;
    cur_marker = marker;
  endtask

  initial begin
    int n;
    int k;
    int mlen;
    int sent;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings (comments off, newline tokens on): byte
    // extremes, quoted token with an escaped quote, empty quoted token,
    // CRLF, lone CR, tab and LF breaks, and a quote left open at the end.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text(" \"a\\\"b\"\"\"\015\n\015w\t\n\"", 1'b1);
    // CR as the last byte; a word, a line break and the end from one byte.
    send_text("x\015", 1'b1);
    send_text("ab\n", 1'b1);

    // Two-byte marker, newline tokens off: a broken marker is a word, a
    // full one skips to the line end, a partial one at the end is a word.
    set_config(3'd2, 32'h0000_2F2F, 1'b1);
    send_text("/a //z\n/", 1'b1);
    send_text("q //", 1'b1);

    // Random phases: each with its own register setting and idling mix.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          set_config(3'd2, 32'h0000_2F2F, 1'b0);
          idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          // Length past the marker size acts as four bytes.
          set_config(3'd7, 32'hFFFF_FFFF, 1'b1);
          idle_pct = 72; stall_pct = 0;
        end
        2: begin
          // Marker holding a quote and a space in its tail.
          set_config(3'd4, 32'h3B20_2278, 1'b0);
          idle_pct = 0;  stall_pct = 72;
        end
        3: begin
          // Marker led by a quote never matches.
          set_config(3'd1, 32'h0000_0022, 1'b1);
          idle_pct = 6;  stall_pct = 6;
        end
        default: begin
          set_config(3'd1, 32'h0000_0023, 1'b0);
          idle_pct = 0;  stall_pct = 0;
        end
      endcase
      mlen = (cur_len > ttok_pkg::MARKER_BYTES) ? ttok_pkg::MARKER_BYTES : cur_len;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        // Build one buffer out of words, blanks, line breaks, quotes,
        // escapes, markers (some cut short) and raw noise.
        n = $urandom_range(24, 1);
        text_q.delete();
        while (text_q.size() < n) begin
          case ($urandom_range(11))
            0, 1, 2, 3: text_q.push_back(8'h61 + 8'($urandom_range(25)));
            4: text_q.push_back($urandom_range(1) ? ttok_pkg::CH_SPACE : ttok_pkg::CH_TAB);
            5: begin
              k = $urandom_range(2);
              if (k != 1) text_q.push_back(ttok_pkg::CH_CR);
              if (k != 0) text_q.push_back(ttok_pkg::CH_LF);
            end
            6: text_q.push_back(ttok_pkg::CH_QUOTE);
            7: begin
              text_q.push_back(ttok_pkg::CH_BSLASH);
              if ($urandom_range(1)) text_q.push_back(ttok_pkg::CH_QUOTE);
            end
            8, 9: begin
              if (mlen == 0) begin
                text_q.push_back(8'h2F);
              end else begin
                k = ($urandom_range(3) == 0) ? $urandom_range(mlen, 1) : mlen;
                for (int j = 0; j < k; j++) text_q.push_back(cur_marker[j*8 +: 8]);
              end
            end
            10: text_q.push_back(8'($urandom_range(255)));
            default: begin
              text_q.push_back(ttok_pkg::CH_QUOTE);
              k = $urandom_range(3);
              for (int j = 0; j < k; j++) text_q.push_back(8'h41 + 8'($urandom_range(25)));
              text_q.push_back(ttok_pkg::CH_QUOTE);
            end
          endcase
        end
        for (int i = 0; i < text_q.size(); i++) begin
          send_byte(text_q[i], i == text_q.size() - 1);
        end
        sent += text_q.size();
      end
    end

    settle();
    if (fail_count == 0 && tokens_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
